// ===== rtl/hex_element_node_address_assert.svh =====
// Assertion macros shared by the hex element node address RTL
`ifndef HEX_ELEMENT_NODE_ADDRESS_ASSERT_SVH
`define HEX_ELEMENT_NODE_ADDRESS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Hold cond on every clock outside reset
`define HENA_ASSERT_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hena: invariant violated");
// Require cons in the same cycle as ante
`define HENA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hena: implication violated");
// Require cons in the cycle after ante
`define HENA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hena: next-cycle check violated");
`else
`define HENA_ASSERT_CHECK(label, cond)
`define HENA_ASSERT_IMPLIES(label, ante, cons)
`define HENA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/hena_pkg.sv =====
// Types, constants and step functions of the hex element node address block
package hena_pkg;

    localparam int ELEM_W     = 30;
    localparam int CORNER_W   = 4;
    localparam int DIM_W      = 13;
    localparam int IDX_W      = 12;
    localparam int LAYER_W    = 6;
    localparam int PL_W       = 2 * IDX_W;
    localparam int PLANE_W    = 2 * IDX_W + 1;
    localparam int TAIL_W     = PLANE_W + 1;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    localparam int DIV1_STEPS = ELEM_W;
    localparam int DIV2_STEPS = IDX_W;
    localparam int NUM_STAGES = 1 + DIV1_STEPS + DIV2_STEPS + 3;

    localparam logic [DIM_W-1:0]    DIM_MIN     = DIM_W'(2);
    localparam logic [DIM_W-1:0]    DIM_MAX     = DIM_W'(4096);
    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(7);
    localparam int                  TOP_FACE_BIT = 2;

    typedef enum logic {
        REG_NODE_ROWS = 1'b0,
        REG_NODE_COLS = 1'b1
    } reg_index_t;

    // position of a corner on its face, counter-clockwise from lower left
    typedef enum logic [1:0] {
        CORNER_LL = 2'd0,
        CORNER_LR = 2'd1,
        CORNER_UR = 2'd2,
        CORNER_UL = 2'd3
    } corner_pos_t;

    typedef struct packed {
        logic [PL_W-1:0]     rem;
        logic [ELEM_W-1:0]   work;
        logic [CORNER_W-1:0] corner;
    } div1_t;

    typedef struct packed {
        logic [IDX_W-1:0]    rem;
        logic [IDX_W-1:0]    work;
        logic [ELEM_W-1:0]   layer;
        logic [CORNER_W-1:0] corner;
    } div2_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  base;
        logic [PLANE_W-1:0] row_off;
        logic [PLANE_W-1:0] corner_off;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [LAYER_W-1:0] layer;
        logic               bad;
    } mul_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  base;
        logic [TAIL_W-1:0]  tail;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [LAYER_W-1:0] layer;
        logic               bad;
    } add_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  global_node;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [LAYER_W-1:0] layer;
        logic               bad;
    } out_t;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
        begin
            r = DIM_MIN;
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // one restoring step of element / per_layer
    function automatic div1_t div1_step(div1_t s, logic [PL_W-1:0] d);
        logic [PL_W:0] trial;
        div1_t         n;
        trial  = {s.rem, s.work[ELEM_W-1]};
        n      = s;
        if (trial >= {1'b0, d})
        begin
            n.rem  = PL_W'(trial - {1'b0, d});
            n.work = {s.work[ELEM_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = trial[PL_W-1:0];
            n.work = {s.work[ELEM_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // remainder within a layer is below erows*ecols, so its upper half is below ecols
    function automatic div2_t div2_init(div1_t s);
        div2_t n;
        n.rem    = s.rem[PL_W-1:IDX_W];
        n.work   = s.rem[IDX_W-1:0];
        n.layer  = s.work;
        n.corner = s.corner;
        return n;
    endfunction

    // one restoring step of in-layer remainder / ecols
    function automatic div2_t div2_step(div2_t s, logic [IDX_W-1:0] d);
        logic [IDX_W:0] trial;
        div2_t          n;
        trial = {s.rem, s.work[IDX_W-1]};
        n     = s;
        if (trial >= {1'b0, d})
        begin
            n.rem  = IDX_W'(trial - {1'b0, d});
            n.work = {s.work[IDX_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = trial[IDX_W-1:0];
            n.work = {s.work[IDX_W-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ===== rtl/hena_if.sv =====
// Stream interfaces for element requests and node replies
interface hena_req_if;
    import hena_pkg::*;

    logic                valid;
    logic                ready;
    logic [ELEM_W-1:0]   element_number;
    logic [CORNER_W-1:0] local_node;

    modport source (output valid, element_number, local_node, input ready);
    modport sink   (input valid, element_number, local_node, output ready);
endinterface

interface hena_rsp_if;
    import hena_pkg::*;

    logic               valid;
    logic               ready;
    logic [ELEM_W-1:0]  global_node;
    logic [IDX_W-1:0]   elem_row;
    logic [IDX_W-1:0]   elem_col;
    logic [LAYER_W-1:0] elem_layer;
    logic               bad_corner;

    modport source (output valid, global_node, elem_row, elem_col, elem_layer, bad_corner,
                    input ready);
    modport sink   (input valid, global_node, elem_row, elem_col, elem_layer, bad_corner,
                    output ready);
endinterface

// ===== rtl/hex_element_node_address.sv =====
// Top level of the hex element node address pipeline
// Each request passes through 46 register stages before its reply is valid.
// Throughput: one transfer per cycle when not stalled; the 30-step layer divider
// and the 12-step row divider are fully pipelined, one quotient bit per stage.
// Backpressure freezes every stage at once while the output register holds a reply.
// Reset clears all stage valid bits and sets node_rows and node_cols to 2.
`include "hex_element_node_address_assert.svh"

module hex_element_node_address (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hena_pkg::ADDR_W-1:0]   paddr,
    input  logic [hena_pkg::DATA_W-1:0]   pwdata,
    output logic [hena_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    hena_req_if.sink                      request,
    hena_rsp_if.source                    reply
);
    import hena_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] rows_reg, rows_next;
    logic [DIM_W-1:0] cols_reg, cols_next;
    reg_index_t       reg_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[REG_SEL_BIT]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Saturate written dimensions into [2, 4096] so no divisor is ever zero
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_NODE_ROWS: rows_next = clamp_dim(pwdata[DIM_W-1:0]);
                REG_NODE_COLS: cols_next = clamp_dim(pwdata[DIM_W-1:0]);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_MIN;
            cols_reg <= DIM_MIN;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NODE_ROWS: prdata = DATA_W'(rows_reg);
            REG_NODE_COLS: prdata = DATA_W'(cols_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Mesh constants derived from the configuration. They track the
    // registers through one more register; the first stage that reads
    // them works in the cycle after acceptance, so a request right after
    // a write sees the new values.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   erows_reg, erows_next;
    logic [IDX_W-1:0]   ecols_reg, ecols_next;
    logic [PL_W-1:0]    per_layer_reg, per_layer_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;

    always_comb
    begin
        erows_next     = IDX_W'(rows_reg - DIM_W'(1));
        ecols_next     = IDX_W'(cols_reg - DIM_W'(1));
        per_layer_next = PL_W'(erows_next) * PL_W'(ecols_next);
        plane_next     = PLANE_W'(rows_reg) * PLANE_W'(cols_reg);
    end

    always_ff @(posedge clk)
    begin
        erows_reg     <= erows_next;
        ecols_reg     <= ecols_next;
        per_layer_reg <= per_layer_next;
        plane_reg     <= plane_next;
    end

    // ------------------------------------------------------------------
    // Pipeline control: one valid bit per stage, all stages advance
    // together unless the output register holds a reply that is not taken.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic                  adv;

    assign adv           = !valid_reg[NUM_STAGES-1] || reply.ready;
    assign request.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], request.valid};
        end
    end

    // ------------------------------------------------------------------
    // Layer divider: stage 0 captures the request, stages 1..30 each
    // resolve one quotient bit of element_number / per_layer.
    // ------------------------------------------------------------------
    div1_t d1_reg  [DIV1_STEPS+1];
    div1_t d1_next [DIV1_STEPS+1];

    always_comb
    begin
        d1_next[0].rem    = '0;
        d1_next[0].work   = request.element_number;
        d1_next[0].corner = request.local_node;
        for (int k = 1; k <= DIV1_STEPS; k++)
        begin
            d1_next[k] = div1_step(d1_reg[k-1], per_layer_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV1_STEPS; k++)
            begin
                d1_reg[k] <= d1_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Row divider: the in-layer remainder over ecols, one bit per stage.
    // The row fits 12 bits, so only 12 steps are needed; the final
    // remainder is the column.
    // ------------------------------------------------------------------
    div2_t d2_reg  [1:DIV2_STEPS];
    div2_t d2_next [1:DIV2_STEPS];

    always_comb
    begin
        d2_next[1] = div2_step(div2_init(d1_reg[DIV1_STEPS]), ecols_reg);
        for (int k = 2; k <= DIV2_STEPS; k++)
        begin
            d2_next[k] = div2_step(d2_reg[k-1], ecols_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= DIV2_STEPS; k++)
            begin
                d2_reg[k] <= d2_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: layer * plane (kept to 30 bits, the node number
    // wraps), row * cols, and the corner offset on its face.
    // ------------------------------------------------------------------
    mul_t             mul_reg, mul_next;
    div2_t            d2_last;
    logic [PLANE_W-1:0] face_off;

    assign d2_last = d2_reg[DIV2_STEPS];

    always_comb
    begin
        unique case (corner_pos_t'(d2_last.corner[1:0]))
            CORNER_LL: face_off = '0;
            CORNER_LR: face_off = PLANE_W'(1);
            CORNER_UR: face_off = PLANE_W'(cols_reg) + PLANE_W'(1);
            CORNER_UL: face_off = PLANE_W'(cols_reg);
        endcase
        mul_next.base    = d2_last.layer * ELEM_W'(plane_reg);
        mul_next.row_off = PLANE_W'(d2_last.work) * PLANE_W'(cols_reg);
        // top face sits one full node plane above the bottom face
        mul_next.corner_off = (d2_last.corner[TOP_FACE_BIT] ? plane_reg : '0) + face_off;
        mul_next.row     = d2_last.work;
        mul_next.col     = d2_last.rem;
        mul_next.layer   = d2_last.layer[LAYER_W-1:0];
        mul_next.bad     = (d2_last.corner > LAST_CORNER);
    end

    // ------------------------------------------------------------------
    // Add stage: sum the small terms first, the wide base joins last.
    // ------------------------------------------------------------------
    add_t add_reg, add_next;

    always_comb
    begin
        add_next.base  = mul_reg.base;
        add_next.tail  = TAIL_W'(mul_reg.row_off) + TAIL_W'(mul_reg.col)
                       + TAIL_W'(mul_reg.corner_off);
        add_next.row   = mul_reg.row;
        add_next.col   = mul_reg.col;
        add_next.layer = mul_reg.layer;
        add_next.bad   = mul_reg.bad;
    end

    // ------------------------------------------------------------------
    // Output register: a bad corner reports node zero but keeps the
    // decoded row, column and layer.
    // ------------------------------------------------------------------
    out_t out_reg, out_next;

    always_comb
    begin
        out_next.global_node = add_reg.bad ? '0 : add_reg.base + ELEM_W'(add_reg.tail);
        out_next.row         = add_reg.row;
        out_next.col         = add_reg.col;
        out_next.layer       = add_reg.layer;
        out_next.bad         = add_reg.bad;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_reg <= mul_next;
            add_reg <= add_next;
            out_reg <= out_next;
        end
    end

    assign reply.valid       = valid_reg[NUM_STAGES-1];
    assign reply.global_node = out_reg.global_node;
    assign reply.elem_row    = out_reg.row;
    assign reply.elem_col    = out_reg.col;
    assign reply.elem_layer  = out_reg.layer;
    assign reply.bad_corner  = out_reg.bad;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HENA_ASSERT_CHECK(a_dims_in_range, rows_reg >= DIM_MIN && rows_reg <= DIM_MAX && cols_reg >= DIM_MIN && cols_reg <= DIM_MAX)
    `HENA_ASSERT_NEXT(a_stall_holds_valids, !adv, $stable(valid_reg))
    `HENA_ASSERT_IMPLIES(a_layer_rem_bound, valid_reg[DIV1_STEPS], d1_reg[DIV1_STEPS].rem < per_layer_reg)
    `HENA_ASSERT_IMPLIES(a_row_bound, valid_reg[DIV1_STEPS+DIV2_STEPS], d2_reg[DIV2_STEPS].work < erows_reg)

endmodule

// ===== tb/hex_element_node_address_test.sv =====
// Self-checking testbench for the hex element node address pipeline
module hex_element_node_address_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hena_pkg::*;

    // Reply latency; the final drain allows margin on top of it.
    localparam int      REPLY_LATENCY   = 45;
    localparam int      DRAIN_LIMIT     = 20000;
    localparam longint  CYCLE_LIMIT     = 400000;
    localparam int      ITEMS_PER_PHASE = 128;
    localparam int      RANDOM_PHASES   = 12;
    localparam int      MESH_LAYERS     = 64;

    logic clk = 1'b0;
    logic rst_n;

    // APB-style register port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    hena_req_if request_bus ();
    hena_rsp_if reply_bus ();

    hex_element_node_address u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (request_bus),
        .reply   (reply_bus)
    );

    // Mesh size as the block should hold it after saturation.
    logic [DIM_W-1:0] rows_now = DIM_MIN;
    logic [DIM_W-1:0] cols_now = DIM_MIN;

    // Replies still owed by the block, oldest first.
    out_t        pending_nodes[$];
    int unsigned mismatches = 0;
    longint      cycles     = 0;

    // Idle controls: percent chance of starting a burst; calm turns bursts off.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          calm          = 1'b0;

    // Toggle the clock: 1 ns high, 1 ns low.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort the run once it exceeds CYCLE_LIMIT, as when the block stops making progress.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL hex_element_node_address");
            $finish;
        end
    end

    // Saturate a written register word the way the block stores it:
    // only the low 13 bits count, then clamp into [2, 4096].
    function automatic logic [DIM_W-1:0] saturate_dim(logic [DATA_W-1:0] word);
        logic [DIM_W-1:0] v;
        v = word[DIM_W-1:0];
        if (v < DIM_MIN)
        begin
            v = DIM_MIN;
        end
        else if (v > DIM_MAX)
        begin
            v = DIM_MAX;
        end
        return v;
    endfunction

    // Decode the element into layer, row and column, then address the corner.
    // Corners run counter-clockwise from the lower left, bottom face first.
    function automatic out_t locate_corner(logic [ELEM_W-1:0] elem,
                                           logic [CORNER_W-1:0] corner);
        longint unsigned rows;
        longint unsigned cols;
        longint unsigned elem_wide;
        longint unsigned per_layer;
        longint unsigned plane;
        longint unsigned layer;
        longint unsigned rest;
        longint unsigned row;
        longint unsigned col;
        longint unsigned node;
        out_t            r;
        rows      = 64'(rows_now);
        cols      = 64'(cols_now);
        elem_wide = 64'(elem);
        per_layer = (rows - 1) * (cols - 1);
        plane     = rows * cols;
        layer     = elem_wide / per_layer;
        rest      = elem_wide - layer * per_layer;
        row       = rest / (cols - 1);
        col       = rest - row * (cols - 1);
        node      = 0;
        r.bad     = (corner > LAST_CORNER);
        // A bad corner still reports the decoded position, but no node.
        if (!r.bad)
        begin
            node = layer * plane + row * cols + col;
            if (corner[TOP_FACE_BIT])
            begin
                node += plane;
            end
            case (corner_pos_t'(corner[1:0]))
                CORNER_LR: node += 1;
                CORNER_UR: node += cols + 1;
                CORNER_UL: node += cols;
                default: ;
            endcase
        end
        // Elements past the mesh are checked too: the node wraps to 30 bits
        // and the layer wraps to 6 bits.
        r.global_node = ELEM_W'(node);
        r.row         = IDX_W'(row);
        r.col         = IDX_W'(col);
        r.layer       = LAYER_W'(layer);
        return r;
    endfunction

    // Highest element number that stays inside a 64-layer mesh.
    function automatic logic [ELEM_W-1:0] mesh_top();
        longint unsigned top;
        top = longint'(rows_now - 1) * longint'(cols_now - 1) * MESH_LAYERS - 1;
        if (top > 64'({ELEM_W{1'b1}}))
        begin
            top = 64'({ELEM_W{1'b1}});
        end
        return ELEM_W'(top);
    endfunction

    // Write one register: setup cycle, then access until pready.
    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] word);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_SEL_BIT;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NODE_ROWS)
        begin
            rows_now = saturate_dim(word);
        end
        else
        begin
            cols_now = saturate_dim(word);
        end
    endtask

    task automatic set_mesh(logic [DATA_W-1:0] row_word, logic [DATA_W-1:0] col_word);
        write_reg(REG_NODE_ROWS, row_word);
        write_reg(REG_NODE_COLS, col_word);
    endtask

    // Offer one request and hold it until the transfer; record what it owes.
    task automatic send_request(logic [ELEM_W-1:0] elem, logic [CORNER_W-1:0] corner);
        int unsigned gap;
        if (!calm && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 15);
            request_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_bus.valid          <= 1'b1;
        request_bus.element_number <= elem;
        request_bus.local_node     <= corner;
        @(posedge clk);
        while (!request_bus.ready)
        begin
            @(posedge clk);
        end
        pending_nodes.push_back(locate_corner(elem, corner));
    endtask

    // Drop valid and wait until every owed reply has come back, or DRAIN_LIMIT runs out.
    task automatic drain_replies();
        int n;
        request_bus.valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && pending_nodes.size() != 0; n++)
        begin
            @(posedge clk);
        end
    endtask

    // Pick a register word: the bounds, small and large meshes, and
    // out-of-range words that must saturate; any may get junk above bit 12.
    function automatic logic [DATA_W-1:0] pick_dim_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 5))
            0: w = DATA_W'(DIM_MIN);
            1: w = DATA_W'(DIM_MAX);
            2: w = DATA_W'($urandom_range(2, 12));
            3: w = DATA_W'($urandom_range(2, 4096));
            4: w = DATA_W'($urandom_range(0, 1));
            default: w = DATA_W'($urandom_range(4097, 8191));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            w[DATA_W-1:DIM_W] = (DATA_W-DIM_W)'($urandom);
        end
        return w;
    endfunction

    // Reset dimensions: one element per layer, so the layer is the element.
    task automatic test_reset_mesh();
        send_request(ELEM_W'(0), CORNER_W'(0));
        send_request(ELEM_W'(0), CORNER_W'(5));
        send_request(ELEM_W'(0), CORNER_W'(8));
        send_request({ELEM_W{1'b1}}, CORNER_W'(7));
        send_request({ELEM_W{1'b1}}, CORNER_W'(15));
        send_request(ELEM_W'(5), CORNER_W'(3));
        drain_replies();
    endtask

    // Walk every corner of one element, plus bad corners.
    task automatic test_corner_order();
        int c;
        set_mesh(32'd3, 32'd4);
        for (c = 0; c <= LAST_CORNER; c++)
        begin
            send_request(ELEM_W'(10), CORNER_W'(c));
        end
        send_request(ELEM_W'(10), CORNER_W'(8));
        send_request(ELEM_W'(10), {CORNER_W{1'b1}});
        drain_replies();
    endtask

    // Largest mesh: last element of the last layer and of the first layer, plus the top element.
    task automatic test_largest_mesh();
        set_mesh(DATA_W'(DIM_MAX), DATA_W'(DIM_MAX));
        send_request(ELEM_W'(4095 * 4095 * MESH_LAYERS - 1), CORNER_W'(6));
        send_request(ELEM_W'(4095 * 4095 - 1), CORNER_W'(2));
        send_request({ELEM_W{1'b1}}, CORNER_W'(4));
        drain_replies();
    endtask

    // Out-of-range writes saturate to the bounds; upper word bits are ignored.
    task automatic test_saturation();
        set_mesh(32'd0, 32'd8191);
        send_request(ELEM_W'(4096), CORNER_W'(1));
        drain_replies();
        set_mesh(32'h8000_0001, 32'h0000_1001);
        send_request(ELEM_W'(8000), CORNER_W'(2));
        drain_replies();
        set_mesh(32'd4097, 32'd1);
        send_request(ELEM_W'(9000), CORNER_W'(3));
        drain_replies();
    endtask

    // Random phases, each with its own mesh and idle mix; the last is calm.
    task automatic test_random_stream();
        int                  p;
        int                  i;
        int unsigned         mix [3] = '{0, 10, 30};
        logic [ELEM_W-1:0]   elem;
        logic [CORNER_W-1:0] corner;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
            begin
                calm = 1'b1;
            end
            send_idle_pct = mix[$urandom_range(0, 2)];
            stall_pct     = mix[$urandom_range(0, 2)];
            set_mesh(pick_dim_word(), pick_dim_word());
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Mostly elements inside the mesh; some anywhere in 30 bits.
                if ($urandom_range(0, 99) < 15)
                begin
                    elem = ELEM_W'($urandom);
                end
                else
                begin
                    elem = ELEM_W'($urandom_range(0, mesh_top()));
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    corner = CORNER_W'($urandom_range(8, 15));
                end
                else
                begin
                    corner = CORNER_W'($urandom_range(0, 7));
                end
                send_request(elem, corner);
            end
            drain_replies();
        end
    endtask

    // Drive backpressure: random stall bursts at stall_pct, none while calm.
    initial
    begin : ready_pattern
        int unsigned hold;
        hold = 0;
        reply_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
                reply_bus.ready <= 1'b0;
            end
            else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(1, 15) - 1;
                reply_bus.ready <= 1'b0;
            end
            else
            begin
                reply_bus.ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    // Check each reply transfer against the oldest owed reply.
    always @(posedge clk)
    begin : check_reply
        out_t want;
        if (rst_n && reply_bus.valid && reply_bus.ready)
        begin
            if (pending_nodes.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: reply with none owed, expected none actual node %0d",
                         $time, reply_bus.global_node);
            end
            else
            begin
                want = pending_nodes.pop_front();
                compare_field("global_node", 32'(want.global_node),
                              32'(reply_bus.global_node));
                compare_field("elem_row", 32'(want.row), 32'(reply_bus.elem_row));
                compare_field("elem_col", 32'(want.col), 32'(reply_bus.elem_col));
                compare_field("elem_layer", 32'(want.layer), 32'(reply_bus.elem_layer));
                compare_field("bad_corner", 32'(want.bad), 32'(reply_bus.bad_corner));
            end
        end
    end

    initial
    begin
        rst_n                      <= 1'b0;
        psel                       <= 1'b0;
        penable                    <= 1'b0;
        pwrite                     <= 1'b0;
        paddr                      <= '0;
        pwdata                     <= '0;
        request_bus.valid          <= 1'b0;
        request_bus.element_number <= '0;
        request_bus.local_node     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Light idling through the directed part.
        send_idle_pct = 20;
        stall_pct     = 20;
        test_reset_mesh();
        test_corner_order();
        test_largest_mesh();
        test_saturation();
        test_random_stream();

        // Let any stray reply surface before judging.
        drain_replies();
        repeat (REPLY_LATENCY + 10) @(posedge clk);
        if (pending_nodes.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: replies owed expected 0 actual %0d", $time, pending_nodes.size());
        end

        if (mismatches == 0)
        begin
            $display("PASS hex_element_node_address");
        end
        else
        begin
            $display("FAIL hex_element_node_address");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hena_pkg.sv
rtl/hena_if.sv
rtl/hex_element_node_address.sv
tb/hex_element_node_address_test.sv
